FILE: hw/rtl/rtp_pkg.sv
// Shared types and constants for the render time predictor.
// No dependencies; every file but rtp_if.sv refers to this package by scoped names.
package rtp_pkg;

    localparam int FRAC_BITS = 16;

    // Widths of the shared serial units
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 31;
    localparam int MUL_AW = 56;
    localparam int MUL_BW = 32;
    localparam int SQ_W   = 56;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SIGMA    = 3'd0,
        CFG_RISE     = 3'd1,
        CFG_MEAN_TC  = 3'd2,
        CFG_VAR_TC   = 3'd3,
        CFG_MAX_PRED = 3'd4
    } t_cfg_idx;

    localparam logic [9:0]  RST_SIGMA    = 10'd640;
    localparam logic [9:0]  RST_RISE     = 10'd461;
    localparam logic [30:0] RST_MEAN_TC  = 31'd180000000;
    localparam logic [30:0] RST_VAR_TC   = 31'd700000000;
    localparam logic [27:0] RST_MAX_PRED = 28'd200000000;

    localparam logic [28:0] NOMINAL_DT = 29'd16666667;
    localparam logic [28:0] MIN_DT     = 29'd1000000;
    localparam logic [28:0] MAX_DT     = 29'd500000000;
    localparam logic [27:0] MIN_SAMPLE = 28'd50000;
    localparam logic [27:0] MAX_SAMPLE = 28'd150000000;
    localparam logic [27:0] STD_FLOOR  = 28'd120000;
    localparam logic [27:0] HEAD_MIN   = 28'd100000;

    // Rates in Q0.16
    localparam logic [15:0] MEAN_RATE_LO = 16'd1311;
    localparam logic [15:0] MEAN_RATE_HI = 16'd19661;
    localparam logic [15:0] VAR_RATE_LO  = 16'd655;
    localparam logic [15:0] VAR_RATE_HI  = 16'd13107;
    localparam logic [15:0] RISE_CAP     = 16'd36045;

endpackage

FILE: hw/rtl/rtp_if.sv
// Valid/ready channel interfaces of the render time predictor.
// Depends on nothing; used by the top level.
interface rtp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] render_time_ns;
    logic [62:0] present_stamp_ns;
    modport source (output valid, render_time_ns, present_stamp_ns, input ready);
    modport sink   (input valid, render_time_ns, present_stamp_ns, output ready);
endinterface

interface rtp_out_if;
    logic        valid;
    logic        ready;
    logic [27:0] prediction_ns;
    modport source (output valid, prediction_ns, input ready);
    modport sink   (input valid, prediction_ns, output ready);
endinterface

interface rtp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [30:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/rtp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rtp_pkg for operand widths.
module rtp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rtp_pkg::DIV_NW-1:0]  i_num,
    input  logic [rtp_pkg::DIV_DW-1:0]  i_den,
    output logic                        o_done,
    output logic [rtp_pkg::DIV_NW-1:0]  o_quo
);
    localparam int CW = $clog2(rtp_pkg::DIV_NW);

    logic [rtp_pkg::DIV_DW-1:0] r_rem, r_den, n_rem;
    logic [rtp_pkg::DIV_NW-1:0] r_quo;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy, r_done, w_ge;
    logic [rtp_pkg::DIV_DW:0]   w_try;

    assign w_try = {r_rem, r_quo[rtp_pkg::DIV_NW-1]};
    assign w_ge  = w_try >= {1'b0, r_den};
    always_comb begin
        n_rem = w_ge ? rtp_pkg::DIV_DW'(w_try - {1'b0, r_den}) : w_try[rtp_pkg::DIV_DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(rtp_pkg::DIV_NW - 1);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                // shift in one numerator bit, retire one quotient bit
                r_rem <= n_rem;
                r_quo <= {r_quo[rtp_pkg::DIV_NW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: hw/rtl/rtp_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on rtp_pkg for operand widths.
module rtp_mul (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic [rtp_pkg::MUL_AW-1:0]                i_a,
    input  logic [rtp_pkg::MUL_BW-1:0]                i_b,
    output logic                                      o_done,
    output logic [rtp_pkg::MUL_AW+rtp_pkg::MUL_BW-1:0] o_prod
);
    localparam int CW = $clog2(rtp_pkg::MUL_BW);

    logic [rtp_pkg::MUL_AW-1:0] r_a, r_hi;
    logic [rtp_pkg::MUL_BW-1:0] r_lo;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy, r_done;
    logic [rtp_pkg::MUL_AW:0]   w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(rtp_pkg::MUL_BW - 1);
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
            end else if (r_busy) begin
                // add partial product, shift the pair right
                r_hi  <= w_sum[rtp_pkg::MUL_AW:1];
                r_lo  <= {w_sum[0], r_lo[rtp_pkg::MUL_BW-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};
endmodule

FILE: hw/rtl/rtp_sqrt.sv
// Integer square root, one result bit (two radicand bits) per cycle.
// Depends on rtp_pkg for the radicand width.
module rtp_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rtp_pkg::SQ_W-1:0]      i_val,
    output logic                          o_done,
    output logic [rtp_pkg::SQ_W/2-1:0]    o_root
);
    localparam int CW = $clog2(rtp_pkg::SQ_W / 2);

    logic [rtp_pkg::SQ_W-1:0] r_v, r_r, r_bit;
    logic [CW-1:0]            r_cnt;
    logic                     r_busy, r_done, w_ge;
    logic [rtp_pkg::SQ_W:0]   w_try;

    assign w_try = {1'b0, r_r} + {1'b0, r_bit};
    assign w_ge  = {1'b0, r_v} >= w_try;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(rtp_pkg::SQ_W / 2 - 1);
                r_v    <= i_val;
                r_r    <= '0;
                r_bit  <= {2'b01, {(rtp_pkg::SQ_W-2){1'b0}}};
            end else if (r_busy) begin
                if (w_ge) begin
                    r_v <= rtp_pkg::SQ_W'({1'b0, r_v} - w_try);
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[rtp_pkg::SQ_W/2-1:0];
endmodule

FILE: hw/rtl/render_time_predictor_unit.sv
// Top level of the render time predictor: sequencer, state and output register.
// Depends on rtp_pkg, the rtp_*_if interfaces, rtp_div, rtp_mul and rtp_sqrt.
//
//  channel  dir  payload                                   transfer when
//  i_in     in   render_time_ns[32], present_stamp_ns[63]  valid & ready
//  i_cfg    in   index[3], data[31]                        valid & ready (ready tied high)
//  o_out    out  prediction_ns[28]                         valid & ready
//
// One item at a time. A seeded item runs four 48-step divisions, four 32-step
// multiplications and a 28-step square root, all run bit by bit on shared units,
// each started by a start strobe and ended by a done strobe, plus the sequencer's
// own steps between them. The first item after reset runs three divisions, two
// multiplications and the square root. Reset is synchronous; it clears the
// sequencer, the mean, the variance and the last stamp and loads the register
// defaults. A result held in the output register does not block the next input
// transfer; only the final step waits for it to drain.
module render_time_predictor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtp_in_if.sink      i_in,
    rtp_cfg_if.sink     i_cfg,
    rtp_out_if.source   o_out
);
    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DIV_A    = 15'b000000000000010,
        S_DIV_V    = 15'b000000000000100,
        S_RISE     = 15'b000000000001000,
        S_MUL_M    = 15'b000000000010000,
        S_ERR      = 15'b000000000100000,
        S_MUL_E    = 15'b000000001000000,
        S_MUL_V    = 15'b000000010000000,
        S_SEED_DIV = 15'b000000100000000,
        S_SEED_MUL = 15'b000001000000000,
        S_SQRT     = 15'b000010000000000,
        S_DIV_F    = 15'b000100000000000,
        S_DIV_H    = 15'b001000000000000,
        S_MUL_S    = 15'b010000000000000,
        S_FIN      = 15'b100000000000000
    } t_state;

    // configuration registers
    logic [9:0]  r_sigma, r_rise;
    logic [30:0] r_mean_tc, r_var_tc;
    logic [27:0] r_max_pred;

    // estimator state
    t_state      r_state;
    logic        r_wait, r_have, r_seeded, r_up;
    logic [62:0] r_last;
    logic [43:0] r_mean, r_floor, r_head;
    logic [55:0] r_var, r_sq;
    logic [27:0] r_s, r_e, r_std;
    logic [28:0] r_dt;
    logic [15:0] r_a, r_va;
    logic [45:0] r_sig;
    logic        r_out_valid;
    logic [27:0] r_pred;

    // shared unit hookup
    logic        w_div_start, w_div_done, w_mul_start, w_mul_done, w_sq_start, w_sq_done;
    logic [47:0] w_div_num, w_div_quo;
    logic [30:0] w_div_den;
    logic [55:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [87:0] w_prod;
    logic [27:0] w_root;

    // combinational helpers
    logic [27:0] w_s_in;
    logic [28:0] w_dt_in;
    logic [62:0] w_gap;
    logic [43:0] w_s_q, w_mag, w_robust;
    logic [55:0] w_blend, w_vdiff;
    logic        w_vup;
    logic [25:0] w_boost;
    logic [16:0] w_boost_q;
    logic [30:0] w_mtc, w_vtc;
    logic [47:0] w_pred_sum;
    logic [31:0] w_p;
    logic [27:0] w_p_clamped;
    logic        w_go;

    assign w_s_q  = {r_s, 16'b0};
    assign w_mtc  = (r_mean_tc == '0) ? 31'd1 : r_mean_tc;
    assign w_vtc  = (r_var_tc == '0) ? 31'd1 : r_var_tc;

    // clamp the incoming sample and derive the frame interval
    always_comb begin
        if (i_in.render_time_ns < {4'b0, rtp_pkg::MIN_SAMPLE}) begin
            w_s_in = rtp_pkg::MIN_SAMPLE;
        end else if (i_in.render_time_ns > {4'b0, rtp_pkg::MAX_SAMPLE}) begin
            w_s_in = rtp_pkg::MAX_SAMPLE;
        end else begin
            w_s_in = i_in.render_time_ns[27:0];
        end
        w_gap = i_in.present_stamp_ns - r_last;
        if (!r_have || i_in.present_stamp_ns <= r_last) begin
            w_dt_in = rtp_pkg::NOMINAL_DT;
        end else if (w_gap < {34'b0, rtp_pkg::MIN_DT}) begin
            w_dt_in = rtp_pkg::MIN_DT;
        end else if (w_gap > {34'b0, rtp_pkg::MAX_DT}) begin
            w_dt_in = rtp_pkg::MAX_DT;
        end else begin
            w_dt_in = w_gap[28:0];
        end
    end

    // rounded blend step: prod / 2^F, half up on the magnitude
    assign w_blend = w_prod[71:16] + {55'b0, w_prod[15]};

    assign w_mag    = (w_s_q >= r_mean) ? w_s_q - r_mean : r_mean - w_s_q;
    assign w_vup    = r_sq >= r_var;
    assign w_vdiff  = w_vup ? r_sq - r_var : r_var - r_sq;
    assign w_robust = ({r_std, 16'b0} > r_floor) ? {r_std, 16'b0} : r_floor;
    assign w_boost  = 26'(r_a) * 26'(r_rise) + 26'd128;
    assign w_boost_q = w_boost[24:8];

    assign w_pred_sum = {4'b0, r_mean} + {2'b0, r_sig} + {4'b0, r_head} + 48'd32768;
    assign w_p        = w_pred_sum[47:16];
    always_comb begin
        if (w_p < {4'b0, rtp_pkg::MIN_SAMPLE}) begin
            w_p_clamped = rtp_pkg::MIN_SAMPLE;
        end else begin
            w_p_clamped = (w_p[31:28] != '0) ? 28'hFFFFFFF : w_p[27:0];
        end
        // cap wins over the floor
        if ({4'b0, w_p_clamped} > {4'b0, r_max_pred} || w_p[31:28] != '0) begin
            w_p_clamped = r_max_pred;
        end
    end

    // operand selection for the shared units
    always_comb begin
        w_div_num = '0;
        w_div_den = 31'd1;
        w_mul_a   = '0;
        w_mul_b   = '0;
        unique case (r_state)
            S_DIV_A: begin
                w_div_num = {3'b0, r_dt, 16'b0} + {18'b0, w_mtc[30:1]};
                w_div_den = w_mtc;
            end
            S_DIV_V: begin
                w_div_num = {3'b0, r_dt, 16'b0} + {18'b0, w_vtc[30:1]};
                w_div_den = w_vtc;
            end
            S_SEED_DIV: begin
                w_div_num = {20'b0, r_s} + 48'd5;
                w_div_den = 31'd10;
            end
            S_DIV_F: begin
                w_div_num = {r_mean, 4'b0} - {4'b0, r_mean} + 48'd500;
                w_div_den = 31'd1000;
            end
            S_DIV_H: begin
                w_div_num = {3'b0, r_mean, 1'b0} + 48'd50;
                w_div_den = 31'd100;
            end
            S_MUL_M: begin
                w_mul_a = {12'b0, w_mag};
                w_mul_b = {16'b0, r_a};
            end
            S_MUL_E, S_SEED_MUL: begin
                w_mul_a = {28'b0, r_e};
                w_mul_b = {4'b0, r_e};
            end
            S_MUL_V: begin
                w_mul_a = w_vdiff;
                w_mul_b = {16'b0, r_va};
            end
            S_MUL_S: begin
                w_mul_a = {12'b0, w_robust};
                w_mul_b = {22'b0, r_sigma};
            end
            default: begin
            end
        endcase
    end

    assign w_div_start = !r_wait && (r_state == S_DIV_A || r_state == S_DIV_V ||
                         r_state == S_SEED_DIV || r_state == S_DIV_F || r_state == S_DIV_H);
    assign w_mul_start = !r_wait && (r_state == S_MUL_M || r_state == S_MUL_E ||
                         r_state == S_SEED_MUL || r_state == S_MUL_V || r_state == S_MUL_S);
    assign w_sq_start  = !r_wait && r_state == S_SQRT;

    assign w_go = !r_out_valid || o_out.ready;

    // configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma    <= rtp_pkg::RST_SIGMA;
            r_rise     <= rtp_pkg::RST_RISE;
            r_mean_tc  <= rtp_pkg::RST_MEAN_TC;
            r_var_tc   <= rtp_pkg::RST_VAR_TC;
            r_max_pred <= rtp_pkg::RST_MAX_PRED;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rtp_pkg::CFG_SIGMA:    r_sigma    <= i_cfg.data[9:0];
                rtp_pkg::CFG_RISE:     r_rise     <= i_cfg.data[9:0];
                rtp_pkg::CFG_MEAN_TC:  r_mean_tc  <= i_cfg.data;
                rtp_pkg::CFG_VAR_TC:   r_var_tc   <= i_cfg.data;
                rtp_pkg::CFG_MAX_PRED: r_max_pred <= i_cfg.data[27:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_have      <= 1'b0;
            r_seeded    <= 1'b0;
            r_last      <= '0;
            r_mean      <= '0;
            r_var       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once it transfers, unless the final step reloads it
            if (o_out.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            if (w_div_start || w_mul_start || w_sq_start) begin
                r_wait <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_s     <= w_s_in;
                        r_dt    <= w_dt_in;
                        r_last  <= i_in.present_stamp_ns;
                        r_have  <= 1'b1;
                        r_state <= r_seeded ? S_DIV_A : S_SEED_DIV;
                    end
                end
                S_DIV_A: begin
                    if (w_div_done) begin
                        r_wait <= 1'b0;
                        if (w_div_quo < {32'b0, rtp_pkg::MEAN_RATE_LO}) begin
                            r_a <= rtp_pkg::MEAN_RATE_LO;
                        end else if (w_div_quo > {32'b0, rtp_pkg::MEAN_RATE_HI}) begin
                            r_a <= rtp_pkg::MEAN_RATE_HI;
                        end else begin
                            r_a <= w_div_quo[15:0];
                        end
                        r_state <= S_DIV_V;
                    end
                end
                S_DIV_V: begin
                    if (w_div_done) begin
                        r_wait <= 1'b0;
                        if (w_div_quo < {32'b0, rtp_pkg::VAR_RATE_LO}) begin
                            r_va <= rtp_pkg::VAR_RATE_LO;
                        end else if (w_div_quo > {32'b0, rtp_pkg::VAR_RATE_HI}) begin
                            r_va <= rtp_pkg::VAR_RATE_HI;
                        end else begin
                            r_va <= w_div_quo[15:0];
                        end
                        r_state <= S_RISE;
                    end
                end
                S_RISE: begin
                    // boost the mean rate when the sample rises above the mean
                    if (w_s_q > r_mean) begin
                        r_a <= (w_boost_q > {1'b0, rtp_pkg::RISE_CAP}) ? rtp_pkg::RISE_CAP
                                                                      : w_boost_q[15:0];
                    end
                    r_up    <= w_s_q >= r_mean;
                    r_state <= S_MUL_M;
                end
                S_MUL_M: begin
                    if (w_mul_done) begin
                        r_wait  <= 1'b0;
                        r_mean  <= r_up ? r_mean + w_blend[43:0] : r_mean - w_blend[43:0];
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_e     <= 28'(({1'b0, w_mag} + 45'd32768) >> 16);
                    r_state <= S_MUL_E;
                end
                S_MUL_E: begin
                    if (w_mul_done) begin
                        r_wait  <= 1'b0;
                        r_sq    <= w_prod[55:0];
                        r_state <= S_MUL_V;
                    end
                end
                S_MUL_V: begin
                    if (!r_wait) begin
                        r_up <= w_vup;
                    end else if (w_mul_done) begin
                        r_wait  <= 1'b0;
                        r_var   <= r_up ? r_var + w_blend : r_var - w_blend;
                        r_state <= S_SQRT;
                    end
                end
                S_SEED_DIV: begin
                    if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_e     <= (w_div_quo < {20'b0, rtp_pkg::STD_FLOOR}) ? rtp_pkg::STD_FLOOR
                                                                            : w_div_quo[27:0];
                        r_mean  <= w_s_q;
                        r_state <= S_SEED_MUL;
                    end
                end
                S_SEED_MUL: begin
                    if (w_mul_done) begin
                        r_wait   <= 1'b0;
                        r_var    <= w_prod[55:0];
                        r_seeded <= 1'b1;
                        r_state  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_wait  <= 1'b0;
                        r_std   <= w_root;
                        r_state <= S_DIV_F;
                    end
                end
                S_DIV_F: begin
                    if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_floor <= (w_div_quo < {4'b0, rtp_pkg::STD_FLOOR, 16'b0})
                                   ? {rtp_pkg::STD_FLOOR, 16'b0} : w_div_quo[43:0];
                        r_state <= S_DIV_H;
                    end
                end
                S_DIV_H: begin
                    if (w_div_done) begin
                        r_wait  <= 1'b0;
                        r_head  <= (w_div_quo < {4'b0, rtp_pkg::HEAD_MIN, 16'b0})
                                   ? {rtp_pkg::HEAD_MIN, 16'b0} : w_div_quo[43:0];
                        r_state <= S_MUL_S;
                    end
                end
                S_MUL_S: begin
                    if (w_mul_done) begin
                        r_wait  <= 1'b0;
                        r_sig   <= 46'((w_prod[53:0] + 54'd128) >> 8);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (w_go) begin
                        r_pred      <= w_p_clamped;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.prediction_ns = r_pred;

    rtp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    rtp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    rtp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_var),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );
endmodule
